/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the RTL of the heading change rate unit.
// Bodies compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: implication failed");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`else

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* hw/rtl/hcr_pkg.sv */
// Package for the heading change rate unit: widths, angle constants,
// arctangent table and result structs. No dependencies.
package hcr_pkg;

    localparam int ANGLE_BITS   = 16;
    localparam int COUNT_BITS   = 16;
    localparam int THR_W        = 16;
    localparam int LON_W        = 32;
    localparam int LAT_W        = 31;
    localparam int DX_W         = LON_W + 1;
    localparam int DY_W         = LAT_W + 1;
    localparam int CORDIC_W     = 45;
    localparam int NORM_SHIFT   = 40;
    localparam int ACC_W        = 32;
    localparam int CORDIC_STEPS = 26;
    localparam int STEP_W       = $clog2(CORDIC_STEPS);
    localparam int RATIO_FRAC   = 16;
    localparam int RATIO_W      = 17;
    localparam int OUT_CNT_W    = 16;
    localparam int DIV_NUM_W    = COUNT_BITS + RATIO_FRAC;
    localparam int DIV_CNT_W    = $clog2(DIV_NUM_W);

    localparam logic [ANGLE_BITS-1:0] ANG_ZERO     = '0;
    localparam logic [ANGLE_BITS-1:0] ANG_HALF_PI  = ANGLE_BITS'(1) << (ANGLE_BITS - 2);
    localparam logic [ANGLE_BITS-1:0] ANG_PI       = ANGLE_BITS'(1) << (ANGLE_BITS - 1);
    localparam logic [ANGLE_BITS-1:0] ANG_3HALF_PI = ANG_PI | ANG_HALF_PI;

    typedef struct packed {
        logic                  done;
        logic [ANGLE_BITS-1:0] heading;
    } t_cordic_res;

    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] quotient;
    } t_div_res;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic [ACC_W-1:0] atan_turn(input logic [STEP_W-1:0] idx);
        logic [ACC_W-1:0] v;
        unique case (idx)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051E;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2FA;
            5'd15:   v = 32'h0000517D;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A30;
            5'd19:   v = 32'h00000518;
            5'd20:   v = 32'h0000028C;
            5'd21:   v = 32'h00000146;
            5'd22:   v = 32'h000000A3;
            5'd23:   v = 32'h00000051;
            5'd24:   v = 32'h00000029;
            5'd25:   v = 32'h00000014;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

/* hw/rtl/heading_change_rate_unit.sv */
// Top level of the heading change rate unit: point sequencer, counters,
// config register. Uses hcr_pkg, hcr_cordic, hcr_divider.
//
//   channel  | direction | handshake                | payload
//   ---------+-----------+--------------------------+---------------------------------
//   in       | input     | i_in_valid / o_in_stall  | longitude, latitude, last_point
//   out      | output    | o_out_valid / i_out_stall| turn_ratio, turn_total,
//            |           |                          | change_total, too_short
//   apb      | input     | psel/penable/pready      | paddr, pwdata, prdata
//
// The next point is taken once the current one is done: the first point of a segment
// only counts, an axis or zero step takes the CORDIC shortcut, else it runs 9 to 40
// normalizing shifts, 26 CORDIC steps and a handoff. A last point adds the 32-step
// divider (skipped when the segment is too short), plus any output stall.
// o_in_stall is high from acceptance until the point is done and, on a last
// point, until the result beat is taken. Reset is synchronous; no clearing pass.
`include "assert_macros.svh"

module heading_change_rate_unit import hcr_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_rst_n,

    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic signed [LON_W-1:0]     i_longitude,
    input  logic signed [LAT_W-1:0]     i_latitude,
    input  logic                        i_last_point,

    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [RATIO_W-1:0]          o_turn_ratio,
    output logic [OUT_CNT_W-1:0]        o_turn_total,
    output logic [OUT_CNT_W-1:0]        o_change_total,
    output logic                        o_too_short,

    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    typedef enum logic [2:0] {
        S_IDLE, S_HEAD_GO, S_HEAD_WAIT, S_COUNT, S_FINISH, S_DIV_WAIT, S_OUT
    } t_state;

    localparam logic                  REG_TURN_THRESHOLD = 1'b0;
    localparam logic [THR_W-1:0]      THR_RESET = THR_W'(5461);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam int                    CMP_W     = ANGLE_BITS + THR_W + 1;

    t_state                    r_state;
    logic [THR_W-1:0]          r_threshold;
    logic signed [LON_W-1:0]   r_prev_lon;
    logic signed [LAT_W-1:0]   r_prev_lat;
    logic [ANGLE_BITS-1:0]     r_prev_heading;
    logic [COUNT_BITS-1:0]     r_points;
    logic [COUNT_BITS-1:0]     r_turns;
    logic                      r_last;
    logic signed [DX_W-1:0]    r_dx;
    logic signed [DY_W-1:0]    r_dy;
    logic [RATIO_W-1:0]        r_ratio;
    logic [OUT_CNT_W-1:0]      r_turn_total;
    logic [OUT_CNT_W-1:0]      r_change_total;
    logic                      r_too_short;

    t_cordic_res               w_cordic;
    t_div_res                  w_div;
    logic                      w_cfg_wr;
    logic [ANGLE_BITS-1:0]     w_diff;
    logic [ANGLE_BITS-1:0]     w_fold;
    logic                      w_is_turn;
    logic [COUNT_BITS-1:0]     w_changes;
    logic                      w_div_start;

    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_TURN_THRESHOLD) ? 32'(r_threshold) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THR_RESET;
        end else if (w_cfg_wr && paddr[2] == REG_TURN_THRESHOLD) begin
            r_threshold <= pwdata[THR_W-1:0];
        end
    end

    assign w_diff    = w_cordic.heading - r_prev_heading;
    assign w_fold    = (w_diff > ANG_PI) ? (ANGLE_BITS'(0) - w_diff) : w_diff;
    assign w_is_turn = (CMP_W'(w_fold) << THR_W) > (CMP_W'(r_threshold) << ANGLE_BITS);
    assign w_changes = r_points - COUNT_BITS'(2);
    assign w_div_start = (r_state == S_FINISH) && (r_points >= COUNT_BITS'(3));

    hcr_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_HEAD_GO),
        .i_dx    (r_dx),
        .i_dy    (r_dy),
        .o_res   (w_cordic)
    );

    hcr_divider u_divider (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_div_start),
        .i_turns   (r_turns),
        .i_changes (w_changes),
        .o_res     (w_div)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_prev_lon     <= '0;
            r_prev_lat     <= '0;
            r_prev_heading <= '0;
            r_points       <= '0;
            r_turns        <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_dx       <= DX_W'(i_longitude) - DX_W'(r_prev_lon);
                        r_dy       <= DY_W'(i_latitude) - DY_W'(r_prev_lat);
                        r_prev_lon <= i_longitude;
                        r_prev_lat <= i_latitude;
                        r_last     <= i_last_point;
                        r_state    <= (r_points != '0) ? S_HEAD_GO : S_COUNT;
                    end
                end
                S_HEAD_GO: begin
                    r_state <= S_HEAD_WAIT;
                end
                S_HEAD_WAIT: begin
                    if (w_cordic.done) begin
                        if (r_points >= COUNT_BITS'(2) && w_is_turn && r_turns != COUNT_MAX) begin
                            r_turns <= r_turns + 1'b1;
                        end
                        r_prev_heading <= w_cordic.heading;
                        r_state        <= S_COUNT;
                    end
                end
                S_COUNT: begin
                    if (r_points != COUNT_MAX) begin
                        r_points <= r_points + 1'b1;
                    end
                    r_state <= r_last ? S_FINISH : S_IDLE;
                end
                S_FINISH: begin
                    if (r_points < COUNT_BITS'(3)) begin
                        r_ratio        <= '0;
                        r_turn_total   <= '0;
                        r_change_total <= '0;
                        r_too_short    <= 1'b1;
                        r_state        <= S_OUT;
                    end else begin
                        r_turn_total   <= (32'(r_turns) > 32'hFFFF) ?
                                          OUT_CNT_W'(16'hFFFF) : OUT_CNT_W'(r_turns);
                        r_change_total <= (32'(w_changes) > 32'hFFFF) ?
                                          OUT_CNT_W'(16'hFFFF) : OUT_CNT_W'(w_changes);
                        r_too_short    <= 1'b0;
                        r_state        <= S_DIV_WAIT;
                    end
                    r_points       <= '0;
                    r_turns        <= '0;
                    r_prev_heading <= '0;
                end
                S_DIV_WAIT: begin
                    if (w_div.done) begin
                        r_ratio <= w_div.quotient[RATIO_W-1:0];
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!i_out_stall) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = (r_state == S_OUT);
    assign o_turn_ratio   = r_ratio;
    assign o_turn_total   = r_turn_total;
    assign o_change_total = r_change_total;
    assign o_too_short    = r_too_short;

    `ASSERT_IMPLY(a_turns_le_points, i_clk, i_rst_n, 1'b1, r_turns <= r_points)
    `ASSERT_IMPLY(a_heading_when_waited, i_clk, i_rst_n, w_cordic.done, r_state == S_HEAD_WAIT)
    `ASSERT_IMPLY(a_short_is_zero, i_clk, i_rst_n, o_out_valid && o_too_short,
                  o_turn_ratio == '0 && o_turn_total == '0 && o_change_total == '0)

endmodule

/* hw/rtl/hcr_cordic.sv */
// Iterative heading unit: axis shortcuts, normalizing shift, then one
// CORDIC vectoring step per cycle on a shared shift/add datapath. Uses hcr_pkg.
`include "assert_macros.svh"

module hcr_cordic import hcr_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic signed [DX_W-1:0]     i_dx,
    input  logic signed [DY_W-1:0]     i_dy,
    output t_cordic_res                o_res
);

    typedef enum logic [1:0] {C_IDLE, C_NORM, C_ROT, C_ROUND} t_state;

    localparam logic signed [CORDIC_W-1:0] NORM_LIM =
        {{(CORDIC_W - NORM_SHIFT - 1){1'b0}}, 1'b1, {NORM_SHIFT{1'b0}}};
    localparam logic [STEP_W-1:0] STEP_LAST  = STEP_W'(CORDIC_STEPS - 1);
    localparam logic [ACC_W-1:0]  ROUND_HALF = ACC_W'(1) << (ACC_W - 1 - ANGLE_BITS);
    localparam logic [ACC_W-1:0]  ACC_PI     = ACC_W'(1) << (ACC_W - 1);

    t_state                      r_state;
    logic signed [CORDIC_W-1:0]  r_x;
    logic signed [CORDIC_W-1:0]  r_y;
    logic [ACC_W-1:0]            r_acc;
    logic [STEP_W-1:0]           r_step;
    logic                        r_done;
    logic [ANGLE_BITS-1:0]       r_heading;

    logic signed [CORDIC_W-1:0]  w_dx_ext;
    logic signed [CORDIC_W-1:0]  w_dy_ext;
    logic signed [CORDIC_W-1:0]  w_xs;
    logic signed [CORDIC_W-1:0]  w_ys;
    logic                        w_norm_more;
    logic [ACC_W-1:0]            w_rounded;
    logic [ACC_W-1:0]            w_atan;

    assign w_dx_ext    = CORDIC_W'(i_dx);
    assign w_dy_ext    = CORDIC_W'(i_dy);
    assign w_xs        = r_x >>> r_step;
    assign w_ys        = r_y >>> r_step;
    assign w_norm_more = (r_x < NORM_LIM) && (r_y < NORM_LIM) && (r_y > -NORM_LIM);
    assign w_rounded   = r_acc + ROUND_HALF;
    assign w_atan      = atan_turn(r_step);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                C_IDLE: begin
                    if (i_start) begin
                        if (i_dx == '0 && i_dy == '0) begin
                            r_heading <= ANG_ZERO;
                            r_done    <= 1'b1;
                        end else if (i_dx == '0) begin
                            r_heading <= (i_dy > 0) ? ANG_HALF_PI : ANG_3HALF_PI;
                            r_done    <= 1'b1;
                        end else if (i_dy == '0) begin
                            r_heading <= (i_dx > 0) ? ANG_ZERO : ANG_PI;
                            r_done    <= 1'b1;
                        end else begin
                            if (i_dx < 0) begin
                                r_x   <= -w_dx_ext;
                                r_y   <= -w_dy_ext;
                                r_acc <= ACC_PI;
                            end else begin
                                r_x   <= w_dx_ext;
                                r_y   <= w_dy_ext;
                                r_acc <= '0;
                            end
                            r_state <= C_NORM;
                        end
                    end
                end
                C_NORM: begin
                    if (w_norm_more) begin
                        r_x <= r_x <<< 1;
                        r_y <= r_y <<< 1;
                    end else begin
                        r_step  <= '0;
                        r_state <= C_ROT;
                    end
                end
                C_ROT: begin
                    if (r_y >= 0) begin
                        r_x   <= r_x + w_ys;
                        r_y   <= r_y - w_xs;
                        r_acc <= r_acc + w_atan;
                    end else begin
                        r_x   <= r_x - w_ys;
                        r_y   <= r_y + w_xs;
                        r_acc <= r_acc - w_atan;
                    end
                    if (r_step == STEP_LAST) begin
                        r_state <= C_ROUND;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                C_ROUND: begin
                    r_heading <= w_rounded[ACC_W-1 -: ANGLE_BITS];
                    r_done    <= 1'b1;
                    r_state   <= C_IDLE;
                end
            endcase
        end
    end

    assign o_res.done    = r_done;
    assign o_res.heading = r_heading;

    `ASSERT_NEXT(a_done_single, i_clk, i_rst_n, r_done, !r_done)
    `ASSERT_IMPLY(a_x_positive, i_clk, i_rst_n, r_state == C_ROT, r_x > 0)
    `ASSERT_IMPLY(a_done_idle, i_clk, i_rst_n, r_done, r_state == C_IDLE)

endmodule

/* hw/rtl/hcr_divider.sv */
// Restoring divider, one quotient bit per cycle, for the turn ratio.
// Uses hcr_pkg.
`include "assert_macros.svh"

module hcr_divider import hcr_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [COUNT_BITS-1:0] i_turns,
    input  logic [COUNT_BITS-1:0] i_changes,
    output t_div_res              o_res
);

    logic                  r_busy;
    logic                  r_done;
    logic [DIV_CNT_W-1:0]  r_count;
    logic [DIV_NUM_W-1:0]  r_num;
    logic [COUNT_BITS-1:0] r_rem;
    logic [COUNT_BITS-1:0] r_div;

    logic [COUNT_BITS:0]   w_trial;
    logic                  w_ge;
    logic [COUNT_BITS:0]   w_diff;

    assign w_trial = {r_rem, r_num[DIV_NUM_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_div};
    assign w_diff  = w_trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (!r_busy) begin
                if (i_start) begin
                    r_num   <= {i_turns, {RATIO_FRAC{1'b0}}};
                    r_div   <= i_changes;
                    r_rem   <= '0;
                    r_count <= DIV_CNT_W'(DIV_NUM_W - 1);
                    r_busy  <= 1'b1;
                end
            end else begin
                r_rem <= w_ge ? w_diff[COUNT_BITS-1:0] : w_trial[COUNT_BITS-1:0];
                r_num <= {r_num[DIV_NUM_W-2:0], w_ge};
                if (r_count == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_count <= r_count - 1'b1;
                end
            end
        end
    end

    assign o_res.done     = r_done;
    assign o_res.quotient = r_num;

    `ASSERT_IMPLY(a_rem_below_div, i_clk, i_rst_n, r_busy, r_rem < r_div)
    `ASSERT_NEXT(a_done_single, i_clk, i_rst_n, r_done, !r_done)
    `ASSERT_IMPLY(a_div_nonzero, i_clk, i_rst_n, r_busy, r_div != '0)

endmodule

/* sim/testbench.sv */
`timescale 1ns / 100ps
// Testbench for heading_change_rate_unit: streams GPS point beats, predicts each
// segment's turn count, change count and ratio, and checks every result beat.
// Depends on hcr_pkg and the unit's RTL only.
module testbench;
    import hcr_pkg::*;

    localparam logic [2:0] REG_TURN_THRESHOLD = 3'd0;
    localparam logic [THR_W-1:0] THR_RESET = 16'd5461;
    localparam logic [THR_W-1:0] THR_PI = 16'd32768;
    localparam int unsigned RUN_LIMIT = 2_000_000;
    localparam int SETTLE = 150;
    localparam int PHASES = 6;
    localparam int PHASE_POINTS = 108;
    localparam int COUNT_MAX = (1 << COUNT_BITS) - 1;
    localparam int OUT_MAX = (1 << OUT_CNT_W) - 1;
    localparam longint LON_LOW = -1800000000;
    localparam longint LON_HIGH = 1800000000;
    localparam longint LAT_LOW = -900000000;
    localparam longint LAT_HIGH = 900000000;
    localparam longint NORM_LIMIT = longint'(1) << NORM_SHIFT;

    typedef struct packed {
        logic [RATIO_W-1:0]   turn_ratio;
        logic [OUT_CNT_W-1:0] turn_total;
        logic [OUT_CNT_W-1:0] change_total;
        logic                 too_short;
    } t_rate;

    typedef struct packed {
        logic [LON_W-1:0] lon;
        logic [LAT_W-1:0] lat;
        logic             last;
        logic             typed;
        t_rate            want;
    } t_point_row;

    localparam t_rate NO_RATE = '0;
    localparam t_rate SHORT_RATE = '{17'd0, 16'd0, 16'd0, 1'b1};

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_in_valid;
    logic                    o_in_stall;
    logic signed [LON_W-1:0] i_longitude;
    logic signed [LAT_W-1:0] i_latitude;
    logic                    i_last_point;
    logic                    o_out_valid;
    logic                    i_out_stall = 1'b0;
    logic [RATIO_W-1:0]      o_turn_ratio;
    logic [OUT_CNT_W-1:0]    o_turn_total;
    logic [OUT_CNT_W-1:0]    o_change_total;
    logic                    o_too_short;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [2:0]              paddr;
    logic [31:0]             pwdata;
    logic [31:0]             prdata;
    logic                    pready;

    heading_change_rate_unit uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_longitude    (i_longitude),
        .i_latitude     (i_latitude),
        .i_last_point   (i_last_point),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_turn_ratio   (o_turn_ratio),
        .o_turn_total   (o_turn_total),
        .o_change_total (o_change_total),
        .o_too_short    (o_too_short),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // atan(2^-i) in 2^-32 turn
    bit [31:0] arctan_step [CORDIC_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014
    };

    t_point_row directed_rows [24] = '{
        // one point, then two points: both too short
        '{32'd0, 31'd0, 1'b1, 1'b1, SHORT_RATE},
        '{32'd5, 31'd5, 1'b0, 1'b0, NO_RATE},
        '{32'd7, 31'd9, 1'b1, 1'b1, SHORT_RATE},
        // square walk: one step along each axis direction
        '{32'd0, 31'd0, 1'b0, 1'b0, NO_RATE},
        '{32'd100, 31'd0, 1'b0, 1'b0, NO_RATE},
        '{32'd100, 31'd100, 1'b0, 1'b0, NO_RATE},
        '{32'd0, 31'd100, 1'b0, 1'b0, NO_RATE},
        '{32'd0, 31'd0, 1'b1, 1'b1, '{17'd65536, 16'd3, 16'd3, 1'b0}},
        // zero displacement
        '{32'd0, 31'd0, 1'b0, 1'b0, NO_RATE},
        '{32'd0, 31'd0, 1'b0, 1'b0, NO_RATE},
        '{32'd0, 31'd0, 1'b1, 1'b1, '{17'd0, 16'd0, 16'd1, 1'b0}},
        // straight line, no turns
        '{32'd0, 31'd0, 1'b0, 1'b0, NO_RATE},
        '{32'd3, 31'd4, 1'b0, 1'b0, NO_RATE},
        '{32'd6, 31'd8, 1'b0, 1'b0, NO_RATE},
        '{32'd9, 31'd12, 1'b1, 1'b1, '{17'd0, 16'd0, 16'd2, 1'b0}},
        // field extremes and all quadrants
        '{-32'sd1800000000, -31'sd900000000, 1'b0, 1'b0, NO_RATE},
        '{32'sd1800000000, 31'sd900000000, 1'b0, 1'b0, NO_RATE},
        '{-32'sd1800000000, 31'sd900000000, 1'b0, 1'b0, NO_RATE},
        '{32'h8000_0000, 31'h4000_0000, 1'b0, 1'b0, NO_RATE},
        '{32'h7FFF_FFFF, 31'h3FFF_FFFF, 1'b0, 1'b0, NO_RATE},
        '{32'sd1, -31'sd1, 1'b0, 1'b0, NO_RATE},
        '{-32'sd1, 31'sd2, 1'b0, 1'b0, NO_RATE},
        '{-32'sd3, -31'sd7, 1'b0, 1'b0, NO_RATE},
        '{-32'sd2, 31'sd1, 1'b1, 1'b0, NO_RATE}
    };

    logic [THR_W-1:0]      thr_q16;
    longint                last_lon;
    longint                last_lat;
    logic [ANGLE_BITS-1:0] last_heading;
    int                    point_count;
    int                    turn_count;
    t_rate                 pending_rates [$];
    int                    mismatches = 0;
    bit                    calm = 1'b0;
    longint                walk_lon;
    longint                walk_lat;
    int unsigned           cycle_count = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        while (cycle_count < RUN_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t: %s mismatch, got %0d expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    function automatic longint rand_span(input longint mag);
        return longint'($urandom_range(32'(2 * mag))) - mag;
    endfunction

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // full-circle heading of a displacement, Q16 turns
    function automatic logic [ANGLE_BITS-1:0] heading_turns(input longint dx, input longint dy);
        bit [ACC_W-1:0] acc;
        longint x;
        longint y;
        longint xs;
        longint ys;
        if (dx == 0 && dy == 0) return ANG_ZERO;
        if (dx == 0) return (dy > 0) ? ANG_HALF_PI : ANG_3HALF_PI;
        if (dy == 0) return (dx > 0) ? ANG_ZERO : ANG_PI;
        acc = '0;
        x = dx;
        y = dy;
        if (x < 0) begin
            x = -x;
            y = -y;
            acc = 32'h8000_0000;
        end
        while (x < NORM_LIMIT && y < NORM_LIMIT && y > -NORM_LIMIT) begin
            x = x * 2;
            y = y * 2;
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                acc = acc + arctan_step[i];
            end else begin
                x = x - ys;
                y = y + xs;
                acc = acc - arctan_step[i];
            end
        end
        acc = acc + (32'd1 << (31 - ANGLE_BITS));
        return acc[ACC_W-1 -: ANGLE_BITS];
    endfunction

    // advance the segment state by one point; fires on a last point
    function automatic void track_point(input longint lon, input longint lat, input logic last,
                                        output bit fires, output t_rate r);
        logic [ANGLE_BITS-1:0] h;
        logic [ANGLE_BITS-1:0] d;
        fires = 1'b0;
        r = '0;
        if (point_count >= 1) begin
            h = heading_turns(lon - last_lon, lat - last_lat);
            if (point_count >= 2) begin
                d = h - last_heading;
                if (d > ANG_PI) d = -d;
                if (d > thr_q16 && turn_count < COUNT_MAX) turn_count++;
            end
            last_heading = h;
        end
        last_lon = lon;
        last_lat = lat;
        if (point_count < COUNT_MAX) point_count++;
        if (last) begin
            fires = 1'b1;
            if (point_count < 3) begin
                r.too_short = 1'b1;
            end else begin
                r.turn_ratio = RATIO_W'((longint'(turn_count) << RATIO_FRAC)
                                        / longint'(point_count - 2));
                r.turn_total = OUT_CNT_W'((turn_count > OUT_MAX) ? OUT_MAX : turn_count);
                r.change_total = OUT_CNT_W'((point_count - 2 > OUT_MAX) ? OUT_MAX
                                                                        : point_count - 2);
            end
            point_count = 0;
            turn_count = 0;
            last_heading = '0;
        end
    endfunction

    task automatic send_point(input logic signed [LON_W-1:0] lon,
                              input logic signed [LAT_W-1:0] lat,
                              input logic last, input logic typed, input t_rate want);
        int gap;
        bit fires;
        t_rate got;
        gap = 0;
        if (!calm) while ($urandom_range(99) < 21) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_longitude <= lon;
        i_latitude <= lat;
        i_last_point <= last;
        do @(posedge i_clk); while (o_in_stall);
        track_point(longint'(lon), longint'(lat), last, fires, got);
        if (fires) pending_rates = {pending_rates, (typed ? want : got)};
    endtask

    task automatic wait_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_rates.size() != 0);
    endtask

    task automatic drain();
        wait_results();
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic apb_read(input logic [2:0] addr, output logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        data = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin : result_monitor
        t_rate want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_rates.size() == 0) begin
                report_mismatch("unexpected result beat, turn_total", o_turn_total, 0);
            end else begin
                want = pending_rates.pop_front();
                if (o_turn_ratio !== want.turn_ratio)
                    report_mismatch("turn_ratio", o_turn_ratio, want.turn_ratio);
                if (o_turn_total !== want.turn_total)
                    report_mismatch("turn_total", o_turn_total, want.turn_total);
                if (o_change_total !== want.change_total)
                    report_mismatch("change_total", o_change_total, want.change_total);
                if (o_too_short !== want.too_short)
                    report_mismatch("too_short", o_too_short, want.too_short);
            end
        end
        i_out_stall <= calm ? 1'b0 : ($urandom_range(99) < 21);
    end

    initial begin : stimulus
        logic [31:0] rd;
        logic [THR_W-1:0] thr;
        int sent;
        int seg_len;
        int seg_idx;
        longint mag;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_longitude = '0;
        i_latitude = '0;
        i_last_point = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        thr_q16 = THR_RESET;
        last_lon = 0;
        last_lat = 0;
        last_heading = '0;
        point_count = 0;
        turn_count = 0;
        walk_lon = 0;
        walk_lat = 0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        apb_read(REG_TURN_THRESHOLD, rd);
        if (rd !== 32'(THR_RESET)) report_mismatch("threshold after reset", rd, THR_RESET);

        foreach (directed_rows[k])
            send_point(directed_rows[k].lon, directed_rows[k].lat, directed_rows[k].last,
                       directed_rows[k].typed, directed_rows[k].want);
        drain();

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: thr = '0;
                1: thr = THR_PI;
                3: thr = THR_PI >> 1;
                5: thr = THR_PI - 1'b1;
                default: thr = THR_W'($urandom_range(32'(THR_PI)));
            endcase
            psel <= 1'b1;
            penable <= 1'b0;
            pwrite <= 1'b1;
            paddr <= REG_TURN_THRESHOLD;
            pwdata <= 32'(thr);
            @(posedge i_clk);
            penable <= 1'b1;
            do @(posedge i_clk); while (!pready);
            psel <= 1'b0;
            penable <= 1'b0;
            @(posedge i_clk);
            thr_q16 = thr;
            apb_read(REG_TURN_THRESHOLD, rd);
            if (rd !== 32'(thr)) report_mismatch("threshold readback", rd, thr);

            calm = (ph == 3);
            sent = 0;
            seg_idx = 0;
            while (sent < PHASE_POINTS) begin
                if (ph == 1 && seg_idx == 4) wait_results();
                seg_len = ($urandom_range(9) == 0) ? $urandom_range(1, 2)
                                                   : $urandom_range(3, 14);
                for (int p = 0; p < seg_len; p++) begin
                    case ($urandom_range(9))
                        0: ;
                        1: begin
                            mag = longint'(1) << $urandom_range(24);
                            if ($urandom_range(1)) walk_lon += rand_span(mag);
                            else walk_lat += rand_span(mag);
                        end
                        2: begin
                            walk_lon = longint'($urandom_range(32'd3600000000)) + LON_LOW;
                            walk_lat = longint'($urandom_range(32'd1800000000)) + LAT_LOW;
                        end
                        default: begin
                            mag = longint'(1) << $urandom_range(24);
                            walk_lon += rand_span(mag);
                            walk_lat += rand_span(mag);
                        end
                    endcase
                    walk_lon = clamp(walk_lon, LON_LOW, LON_HIGH);
                    walk_lat = clamp(walk_lat, LAT_LOW, LAT_HIGH);
                    send_point(LON_W'(walk_lon), LAT_W'(walk_lat), p == seg_len - 1,
                               1'b0, NO_RATE);
                end
                sent += seg_len;
                seg_idx++;
            end
            drain();
        end

        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
